// ----- hdl/block_merge_sorter_assert.svh -----
// ----------------------------------------------------------------------------
// block_merge_sorter assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_MERGE_SORTER_ASSERT_SVH
`define BLOCK_MERGE_SORTER_ASSERT_SVH

// same-cycle implication
`define BMS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bms_pkg.sv -----
// ----------------------------------------------------------------------------
// bms_pkg
// Shared value width and the store control bundle of the block merge sorter.
// ----------------------------------------------------------------------------
package bms_pkg;

  localparam int unsigned VAL_W = 32;

  typedef struct packed {
    logic wr_en;
    logic wr_b;
    logic rd_b;
  } bms_ctl_t;

endpackage

// ----- hdl/bms_if.sv -----
// ----------------------------------------------------------------------------
// bms_if
// Valid/ready channels for element requests and sorted result requests.
// ----------------------------------------------------------------------------
interface bms_in_if;
  import bms_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    block_end;

  modport source (output valid, value, block_end, input ready);
  modport sink (input valid, value, block_end, output ready);
endinterface

interface bms_out_if;
  import bms_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sorted_value;
  logic                    run_end;
  logic                    dropped;

  modport source (output valid, sorted_value, run_end, dropped, input ready);
  modport sink (input valid, sorted_value, run_end, dropped, output ready);
endinterface

// ----- hdl/bms_store.sv -----
// ----------------------------------------------------------------------------
// bms_store
// Ping-pong element buffers: two memories, one write and two registered
// reads each, with the heads of the current source buffer selected out.
// ----------------------------------------------------------------------------
module bms_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  bms_pkg::bms_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         head_a,
  output logic [WIDTH-1:0]         head_b
);
  import bms_pkg::*;

  logic [WIDTH-1:0] mem_a [DEPTH];
  logic [WIDTH-1:0] mem_b [DEPTH];
  logic [WIDTH-1:0] a_rd0_r, a_rd1_r, b_rd0_r, b_rd1_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en && !ctl.wr_b) begin
      mem_a[wr_addr] <= wr_data;
    end
    a_rd0_r <= mem_a[rd_addr_a];
    a_rd1_r <= mem_a[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    b_rd0_r <= mem_b[rd_addr_a];
    b_rd1_r <= mem_b[rd_addr_b];
  end

  assign head_a = ctl.rd_b ? b_rd0_r : a_rd0_r;
  assign head_b = ctl.rd_b ? b_rd1_r : a_rd1_r;

endmodule

// ----- hdl/bms_seq.sv -----
// ----------------------------------------------------------------------------
// bms_seq
// Load, merge-pass and emit sequencer: owns fill count, run bookkeeping,
// the merge compare and the store write-back.
// ----------------------------------------------------------------------------
module bms_seq #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [WIDTH-1:0]         in_value,
  input  logic                     in_block_end,
  output bms_pkg::bms_ctl_t        ctl,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output logic [WIDTH-1:0]         wr_data,
  output logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [$clog2(DEPTH)-1:0] rd_addr_b,
  input  logic [WIDTH-1:0]         head_a,
  input  logic [WIDTH-1:0]         head_b,
  output logic                     emit_valid,
  input  logic                     emit_ready,
  output logic [WIDTH-1:0]         emit_data,
  output logic                     emit_last,
  output logic                     emit_drop
);
  import bms_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = CW + 2;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_SEG   = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic            ovf_r, ovf_nxt;
  logic            sel_r, sel_nxt;
  logic [EW-1:0]   run_r, run_nxt;
  logic [EW-1:0]   lo_r, lo_nxt;
  logic [EW-1:0]   mid_r, mid_nxt;
  logic [EW-1:0]   hi_r, hi_nxt;
  logic [EW-1:0]   i_r, i_nxt;
  logic [EW-1:0]   j_r, j_nxt;
  logic [EW-1:0]   k_r, k_nxt;

  logic [EW-1:0]   n_ext;
  logic [EW-1:0]   mid_sum, hi_sum, lo_step, run_dbl;
  logic            take_left;
  logic            in_acc;

  assign n_ext     = EW'(fill_r);
  assign mid_sum   = lo_r + run_r;
  assign hi_sum    = lo_r + (run_r << 1);
  assign lo_step   = lo_r + (run_r << 1);
  assign run_dbl   = run_r << 1;
  assign take_left = (i_r < mid_r) &&
                     ((j_r >= hi_r) || ($signed(head_a) <= $signed(head_b)));
  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;

  assign emit_valid = (state_r == ST_EMIT);
  assign emit_data  = head_a;
  assign emit_last  = (i_r == n_ext - EW'(1));
  assign emit_drop  = ovf_r;

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    ovf_nxt    = ovf_r;
    sel_nxt    = sel_r;
    run_nxt    = run_r;
    lo_nxt     = lo_r;
    mid_nxt    = mid_r;
    hi_nxt     = hi_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    ctl.wr_en  = 1'b0;
    ctl.wr_b   = 1'b0;
    ctl.rd_b   = sel_r;
    wr_addr    = fill_r[AW-1:0];
    wr_data    = in_value;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (fill_r < CW'(DEPTH)) begin
            ctl.wr_en = 1'b1;
            fill_nxt  = fill_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_block_end) begin
            sel_nxt   = 1'b0;
            run_nxt   = EW'(1);
            lo_nxt    = '0;
            state_nxt = ST_SEG;
          end
        end
      end
      ST_SEG: begin
        if (run_r >= n_ext) begin
          i_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          mid_nxt   = (mid_sum > n_ext) ? n_ext : mid_sum;
          hi_nxt    = (hi_sum > n_ext) ? n_ext : hi_sum;
          i_nxt     = lo_r;
          j_nxt     = (mid_sum > n_ext) ? n_ext : mid_sum;
          k_nxt     = lo_r;
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        ctl.wr_en = 1'b1;
        ctl.wr_b  = ~sel_r;
        wr_addr   = k_r[AW-1:0];
        wr_data   = take_left ? head_a : head_b;
        if (take_left) begin
          i_nxt = i_r + EW'(1);
        end else begin
          j_nxt = j_r + EW'(1);
        end
        k_nxt = k_r + EW'(1);
        if (k_r + EW'(1) == hi_r) begin
          state_nxt = ST_SEG;
          lo_nxt    = lo_step;
          if (lo_step >= n_ext) begin
            lo_nxt  = '0;
            run_nxt = run_dbl;
            sel_nxt = ~sel_r;
            if (run_dbl >= n_ext) begin
              i_nxt     = '0;
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (emit_ready) begin
          i_nxt = i_r + EW'(1);
          if (emit_last) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign rd_addr_a = i_nxt[AW-1:0];
  assign rd_addr_b = j_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    lo_r  <= lo_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
  end

endmodule

// ----- hdl/block_merge_sorter.sv -----
// ----------------------------------------------------------------------------
// block_merge_sorter
// Stable ascending sort of blocks of signed values, bottom-up merge sort.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle until a request flagged block_end; the
// block (at most DEPTH elements, extras discarded and dropped set on every
// result) is then merged in place over two memories, one element written per
// merge cycle, and streamed out one result per cycle while the receiver is
// ready, with run_end on the last. A block of n elements is loaded, then
// merged in ceil(log2 n) passes with a setup step per merged run pair
// (only a setup step and no pass when n is 1), then emitted. Each merge
// step goes through the sequencer's single merge write port. No element is
// accepted during the sort or the emit; the next block may start loading
// while the last result still waits in the output register.
module block_merge_sorter #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bms_in_if.sink     in_chan,
  bms_out_if.source  out_chan
);
  import bms_pkg::*;

  localparam int AW = $clog2(DEPTH);

  bms_ctl_t         ctl;
  logic [AW-1:0]    wr_addr, rd_addr_a, rd_addr_b;
  logic [WIDTH-1:0] wr_data, head_a, head_b, in_value;
  logic             emit_valid, emit_ready, emit_last, emit_drop;
  logic [WIDTH-1:0] emit_data;

  logic             out_valid_r;
  logic [WIDTH-1:0] out_data_r;
  logic             out_last_r, out_drop_r;

  assign in_value = WIDTH'(in_chan.value);

  bms_seq #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_value    (in_value),
    .in_block_end(in_chan.block_end),
    .ctl         (ctl),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .head_a      (head_a),
    .head_b      (head_b),
    .emit_valid  (emit_valid),
    .emit_ready  (emit_ready),
    .emit_data   (emit_data),
    .emit_last   (emit_last),
    .emit_drop   (emit_drop)
  );

  bms_store #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_store (
    .clk      (clk),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .head_a   (head_a),
    .head_b   (head_b)
  );

  assign emit_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_data_r <= emit_data;
      out_last_r <= emit_last;
      out_drop_r <= emit_drop;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.sorted_value = VAL_W'(out_data_r);
  assign out_chan.run_end      = out_last_r;
  assign out_chan.dropped      = out_drop_r;

endmodule

// ----- hdl/bms_checker.sv -----
// ----------------------------------------------------------------------------
// bms_checker
// Port-level checks of the block merge sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "block_merge_sorter_assert.svh"

module bms_port_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_block_end,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bms_pkg::VAL_W-1:0] out_sorted_value,
  input logic                      out_run_end,
  input logic                      out_dropped
);
  import bms_pkg::*;

  logic             out_acc;
  logic             out_stall;
  logic             in_last_acc;
  logic             mid_acc;
  logic [VAL_W+1:0] out_payload;
  logic             mid_run_r;
  logic             prev_drop_r;

  assign out_acc     = out_valid && out_ready;
  assign out_stall   = out_valid && !out_ready;
  assign in_last_acc = in_valid && in_ready && in_block_end;
  assign mid_acc     = out_acc && mid_run_r;
  assign out_payload = {out_sorted_value, out_run_end, out_dropped};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_run_r   <= 1'b0;
      prev_drop_r <= 1'b0;
    end else if (out_acc) begin
      mid_run_r   <= !out_run_end;
      prev_drop_r <= out_dropped;
    end
  end

  `BMS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload), "result changed")
  `BMS_ASSERT_NEXT(a_sort_blocks_input, in_last_acc, !in_ready, "input open after block end")
  `BMS_ASSERT_IMPL(a_drop_per_run, mid_acc, out_dropped == prev_drop_r, "dropped changed in run")

endmodule

bind block_merge_sorter bms_port_checker u_bms_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_block_end    (in_chan.block_end),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_sorted_value(out_chan.sorted_value),
  .out_run_end     (out_chan.run_end),
  .out_dropped     (out_chan.dropped)
);

// ----- tb/bms_checker.sv -----
// ----------------------------------------------------------------------------
// bms_checker
// Watches the element and sorted result channels of the block merge sorter.
// Collects each block as it is accepted, sorts it when the block_end request
// arrives, and compares every sorted result request field by field with the
// oldest prediction. Hands the mismatch count and the number of results
// still owed to the testbench top.
// ----------------------------------------------------------------------------
module bms_checker #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  bms_in_if           in_mon,
  bms_out_if          out_mon,
  output int unsigned mismatch_cnt,
  output int unsigned results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import bms_pkg::*;

  localparam int unsigned MAX_LINES = 20;

  typedef logic signed [VAL_W-1:0] elem_t;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic             last;
    logic             ovf;
  } sorted_t;

  elem_t   held_vals[$];
  logic    overflow_flag;
  sorted_t sorted_owed_q[$];

  // bottom-up two-way merge, left run wins ties
  function automatic void sort_ascending(ref elem_t blk[$]);
    elem_t scratch[$];
    int    n;
    int    run;
    int    lo;
    int    mid;
    int    hi;
    int    i;
    int    j;
    int    k;
    scratch = blk;
    n = blk.size();
    for (run = 1; run < n; run = run * 2) begin
      for (lo = 0; lo < n; lo = lo + 2 * run) begin
        mid = (lo + run < n) ? lo + run : n;
        hi  = (lo + 2 * run < n) ? lo + 2 * run : n;
        i = lo;
        j = mid;
        for (k = lo; k < hi; k++) begin
          if (i < mid && (j >= hi || blk[i] <= blk[j])) begin
            scratch[k] = blk[i];
            i++;
          end else begin
            scratch[k] = blk[j];
            j++;
          end
        end
      end
      blk = scratch;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] exp_v,
                                 input logic [VAL_W-1:0] got_v);
    if (mismatch_cnt < MAX_LINES) begin
      $display("%0t ns: mismatch on %s: expected %0d got %0d", $time, what,
               $signed(exp_v), $signed(got_v));
    end
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    sorted_t exp_res;
    int      n;
    if (!rst_n) begin
      held_vals.delete();
      sorted_owed_q.delete();
      overflow_flag = 1'b0;
      mismatch_cnt  = 0;
      results_owed <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (sorted_owed_q.size() == 0) begin
          report_mismatch("unexpected result", '0, out_mon.sorted_value);
        end else begin
          exp_res = sorted_owed_q.pop_front();
          if (out_mon.sorted_value !== exp_res.val) begin
            report_mismatch("sorted_value", exp_res.val, out_mon.sorted_value);
          end
          if (out_mon.run_end !== exp_res.last) begin
            report_mismatch("run_end", exp_res.last, out_mon.run_end);
          end
          if (out_mon.dropped !== exp_res.ovf) begin
            report_mismatch("dropped", exp_res.ovf, out_mon.dropped);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (held_vals.size() < DEPTH) begin
          held_vals.push_back(in_mon.value);
        end else begin
          overflow_flag = 1'b1;
        end
        if (in_mon.block_end) begin
          sort_ascending(held_vals);
          n = held_vals.size();
          for (int k = 0; k < n; k++) begin
            exp_res.val  = held_vals[k];
            exp_res.last = (k == n - 1);
            exp_res.ovf  = overflow_flag;
            sorted_owed_q.push_back(exp_res);
          end
          held_vals.delete();
          overflow_flag = 1'b0;
        end
      end
      results_owed <= sorted_owed_q.size();
    end
  end

endmodule

// ----- tb/block_merge_sorter_tb.sv -----
// ----------------------------------------------------------------------------
// block_merge_sorter_tb
// Stimulus and verdict for the block merge sorter.
// Sends directed blocks (extremes, duplicates, sorted and reversed order),
// a back-pressure phase, then random blocks of mostly small sizes with one
// overlong block. Both channels idle at random; a checker beside the
// block predicts and compares every sorted result.
// ----------------------------------------------------------------------------
module block_merge_sorter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bms_pkg::*;

  localparam int DEPTH       = 64;
  localparam int STALL_LIMIT = 6000;
  localparam int LONG_HOLD   = 400;
  localparam int TOTAL_ITEMS = 110;
  localparam int TAIL_CYCLES = 100;

  typedef logic signed [VAL_W-1:0] elem_t;
  typedef elem_t elem_q_t[$];

  logic        clk;
  logic        rst_n;
  int unsigned mismatch_cnt;
  int unsigned results_owed;
  int unsigned idle_cycles;
  int unsigned hold_asks;
  int unsigned holds_done;
  int unsigned items_sent;

  bms_in_if  in_chan ();
  bms_out_if out_chan ();

  block_merge_sorter #(
    .DEPTH (DEPTH),
    .WIDTH (VAL_W)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  bms_checker #(
    .DEPTH (DEPTH)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .mismatch_cnt (mismatch_cnt),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic elem_t draw_value();
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  task automatic send_elem(input elem_t v, input logic last);
    in_chan.valid     <= 1'b1;
    in_chan.value     <= v;
    in_chan.block_end <= last;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic pause_sender(input int gap);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_block(input elem_q_t vals, input bit calm);
    for (int i = 0; i < vals.size(); i++) begin
      send_elem(vals[i], i == vals.size() - 1);
      items_sent++;
      pause_sender(calm ? 0 : draw_gap());
    end
  endtask

  task automatic send_random_block(input int n);
    elem_q_t vals;
    for (int i = 0; i < n; i++) vals.push_back(draw_value());
    send_block(vals, $urandom_range(0, 3) == 0);
  endtask

  // hold off until every sorted result has come back
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // receiver: random ready with long holds on request
  initial begin
    int run_len;
    int gap;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_asks != holds_done) begin
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        out_chan.ready <= 1'b1;
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 8);
        repeat (run_len) @(posedge clk);
        gap = draw_gap();
        if (gap > 0) begin
          out_chan.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    elem_q_t d;
    int      blk;
    int      n;
    hold_asks  = 0;
    holds_done = 0;
    items_sent = 0;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.value     <= '0;
    in_chan.block_end <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    d = '{32'sh7fff_ffff};
    send_block(d, 1'b0);
    d = '{32'sh7fff_ffff, 32'sh8000_0000};
    send_block(d, 1'b0);
    d = '{32'sh8000_0000, 32'sh7fff_ffff, 0};
    send_block(d, 1'b1);
    d = '{0, -1, 1, 0, -1, 5};
    send_block(d, 1'b0);
    d = '{32'sh5555_5555, 32'shaaaa_aaaa};
    send_block(d, 1'b0);
    d = '{1, 2, 3, 4};
    send_block(d, 1'b1);
    d = '{4, 3, 2, 1};
    send_block(d, 1'b0);
    drain_results();

    // stall the receiver while blocks keep coming
    hold_asks++;
    send_random_block(8);
    send_random_block(8);
    drain_results();

    blk = 0;
    while (items_sent < TOTAL_ITEMS) begin
      case (blk)
        2: send_random_block(DEPTH + 1);
        default: begin
          n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
          send_random_block(n);
        end
      endcase
      if ($urandom_range(0, 9) == 0) drain_results();
      blk++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && results_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/bms_pkg.sv
hdl/bms_if.sv
hdl/bms_store.sv
hdl/bms_seq.sv
hdl/block_merge_sorter.sv
hdl/bms_checker.sv
tb/bms_checker.sv
tb/block_merge_sorter_tb.sv
